>>> rtl/core/trsmb_pkg.sv
// ----------------------------------------------------------------------------
// trsmb_pkg
// shared constants, types and the cordic arctangent table
// ----------------------------------------------------------------------------
package trsmb_pkg;

   // position and scale words are signed Q16.16
   localparam int FRAC_BITS      = 16;
   localparam int ANGLE_BITS_DEF = 16;
   localparam int CORDIC_STEPS   = 30;
   localparam int CORDIC_STAGES  = 10;
   localparam int STEPS_PER_STG  = CORDIC_STEPS / CORDIC_STAGES;
   localparam int CW             = 34;
   localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

   typedef logic signed [CW-1:0] cw_type;
   typedef logic signed [31:0]   word_type;

   typedef struct packed {
      cw_type x;
      cw_type y;
      cw_type z;
      logic   neg;
   } cordic_type;

   function automatic cw_type atan_turn(input int i);
      cw_type r;
      case (i)
         0: r = CW'(32'h20000000);   1: r = CW'(32'h12E4051E);
         2: r = CW'(32'h09FB385B);   3: r = CW'(32'h051111D4);
         4: r = CW'(32'h028B0D43);   5: r = CW'(32'h0145D7E1);
         6: r = CW'(32'h00A2F61E);   7: r = CW'(32'h00517C55);
         8: r = CW'(32'h0028BE53);   9: r = CW'(32'h00145F2F);
         10: r = CW'(32'h000A2F98);  11: r = CW'(32'h000517CC);
         12: r = CW'(32'h00028BE6);  13: r = CW'(32'h000145F3);
         14: r = CW'(32'h0000A2FA);  15: r = CW'(32'h0000517D);
         16: r = CW'(32'h000028BE);  17: r = CW'(32'h0000145F);
         18: r = CW'(32'h00000A30);  19: r = CW'(32'h00000518);
         20: r = CW'(32'h0000028C);  21: r = CW'(32'h00000146);
         22: r = CW'(32'h000000A3);  23: r = CW'(32'h00000051);
         24: r = CW'(32'h00000029);  25: r = CW'(32'h00000014);
         26: r = CW'(32'h0000000A);  27: r = CW'(32'h00000005);
         28: r = CW'(32'h00000003);  29: r = CW'(32'h00000001);
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic cordic_type cordic_step(input cordic_type c, input int i);
      cordic_type r;
      cw_type dx;
      cw_type dy;
      dx = c.y >>> i;
      dy = c.x >>> i;
      r = c;
      if (!c.z[CW-1]) begin
         r.x = c.x - dx;
         r.y = c.y + dy;
         r.z = c.z - atan_turn(i);
      end else begin
         r.x = c.x + dx;
         r.y = c.y - dy;
         r.z = c.z + atan_turn(i);
      end
      return r;
   endfunction

   function automatic cw_type mul30(input cw_type a, input cw_type b);
      logic signed [2*CW-1:0] p;
      p = a * b;
      return p[CW+29:30];
   endfunction

   function automatic word_type sat_round(input logic signed [2*CW-1:0] p);
      logic signed [2*CW-1:0] v;
      v = (p + (68'sd1 <<< 29)) >>> 30;
      if (v > 68'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -68'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

endpackage

>>> rtl/core/trs_model_matrix_builder.sv
// ----------------------------------------------------------------------------
// trs_model_matrix_builder
// model matrix T*Ry*Rx*Rz*S from position, euler angles and scale
// ----------------------------------------------------------------------------
// one request carries position, yaw/pitch/roll binary angles and scales; one
// response carries the top three rows of the model matrix, signed Q16.16.
// the pipeline takes one request per cycle, back to back, while the output
// register is empty or taken. a response is valid once its request has passed
// the angle fold register, ten cordic stages of three iterations each, two
// product stages, the scaling multiply stage and the rounding and saturation
// stage that loads the output register. all stages advance together when the
// output register is empty or taken, so a stalled receiver holds every stage
// and drops req_ready in the same cycle; nothing is lost or repeated.
// reset clears the valid bits only; the data path carries no reset.
// ----------------------------------------------------------------------------
module trs_model_matrix_builder #(
   parameter int ANGLE_BITS = trsmb_pkg::ANGLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  trsmb_pkg::word_type    req_pos_x,
   input  trsmb_pkg::word_type    req_pos_y,
   input  trsmb_pkg::word_type    req_pos_z,
   input  logic [ANGLE_BITS-1:0]  req_angle_yaw,
   input  logic [ANGLE_BITS-1:0]  req_angle_pitch,
   input  logic [ANGLE_BITS-1:0]  req_angle_roll,
   input  trsmb_pkg::word_type    req_scale_x,
   input  trsmb_pkg::word_type    req_scale_y,
   input  trsmb_pkg::word_type    req_scale_z,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output trsmb_pkg::word_type    rsp_m_r0c0,
   output trsmb_pkg::word_type    rsp_m_r0c1,
   output trsmb_pkg::word_type    rsp_m_r0c2,
   output trsmb_pkg::word_type    rsp_m_r0c3,
   output trsmb_pkg::word_type    rsp_m_r1c0,
   output trsmb_pkg::word_type    rsp_m_r1c1,
   output trsmb_pkg::word_type    rsp_m_r1c2,
   output trsmb_pkg::word_type    rsp_m_r1c3,
   output trsmb_pkg::word_type    rsp_m_r2c0,
   output trsmb_pkg::word_type    rsp_m_r2c1,
   output trsmb_pkg::word_type    rsp_m_r2c2,
   output trsmb_pkg::word_type    rsp_m_r2c3
);
   import trsmb_pkg::*;

   localparam int CD    = CORDIC_STAGES + 1;
   localparam int DEPTH = CD + 4;
   localparam int PW    = 2 * CW;

   logic en;
   logic [DEPTH-1:0] vld_ff;
   logic [DEPTH-1:0] vld_in;

   word_type pos_ff [CD][3];
   word_type scl_ff [CD][3];

   cw_type sa, ca, sb, cb, sc, cc;

   // product stage 1
   cw_type p1_ff [10];
   cw_type p1_in [10];
   cw_type sc_d_ff, cc_d_ff, sb_d_ff;
   // product stage 2
   cw_type r_ff [9];
   cw_type r_in [9];
   // scaling multiply and saturation
   logic signed [PW-1:0] m_ff [9];
   word_type o_ff [12];
   word_type o_in [12];
   word_type pos2_ff [3][3];
   word_type scl2_ff [3];
   // scale registered again to line up with r_ff
   word_type scl3_ff [3];

   assign en        = !vld_ff[DEPTH-1] || rsp_ready;
   assign req_ready = en;

   trsmb_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
      .clock(clock), .en(en), .angle(req_angle_yaw), .sin_out(sa), .cos_out(ca));
   trsmb_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
      .clock(clock), .en(en), .angle(req_angle_pitch), .sin_out(sb), .cos_out(cb));
   trsmb_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
      .clock(clock), .en(en), .angle(req_angle_roll), .sin_out(sc), .cos_out(cc));

   always_comb begin
      vld_in = {vld_ff[DEPTH-2:0], req_valid};
      p1_in[0] = mul30(sa, sb);
      p1_in[1] = mul30(ca, sb);
      p1_in[2] = mul30(ca, cc);
      p1_in[3] = mul30(ca, sc);
      p1_in[4] = mul30(sa, cb);
      p1_in[5] = mul30(cb, sc);
      p1_in[6] = mul30(cb, cc);
      p1_in[7] = mul30(sa, cc);
      p1_in[8] = mul30(sa, sc);
      p1_in[9] = mul30(ca, cb);
      // sine and cosine copies registered beside the first products
      r_in[0] = p1_ff[2] + mul30(p1_ff[0], sc_d_ff);
      r_in[1] = mul30(p1_ff[0], cc_d_ff) - p1_ff[3];
      r_in[2] = p1_ff[4];
      r_in[3] = p1_ff[5];
      r_in[4] = p1_ff[6];
      r_in[5] = -sb_d_ff;
      r_in[6] = mul30(p1_ff[1], sc_d_ff) - p1_ff[7];
      r_in[7] = p1_ff[8] + mul30(p1_ff[1], cc_d_ff);
      r_in[8] = p1_ff[9];
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) o_in[r*4+c] = sat_round(m_ff[r*3+c]);
         o_in[r*4+3] = pos2_ff[2][r];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_ff[0][0] <= req_pos_x;
         pos_ff[0][1] <= req_pos_y;
         pos_ff[0][2] <= req_pos_z;
         scl_ff[0][0] <= req_scale_x;
         scl_ff[0][1] <= req_scale_y;
         scl_ff[0][2] <= req_scale_z;
         for (int s = 1; s < CD; s++) begin
            pos_ff[s] <= pos_ff[s-1];
            scl_ff[s] <= scl_ff[s-1];
         end
         p1_ff   <= p1_in;
         sc_d_ff <= sc;
         cc_d_ff <= cc;
         sb_d_ff <= sb;
         r_ff    <= r_in;
         pos2_ff[0] <= pos_ff[CD-1];
         pos2_ff[1] <= pos2_ff[0];
         pos2_ff[2] <= pos2_ff[1];
         scl2_ff[0] <= scl_ff[CD-1][0];
         scl2_ff[1] <= scl_ff[CD-1][1];
         scl2_ff[2] <= scl_ff[CD-1][2];
         scl3_ff    <= scl2_ff;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++)
               m_ff[r*3+c] <= r_ff[r*3+c] * PW'(scl3_ff[c]);
         end
         o_ff <= o_in;
      end
   end

   assign rsp_valid  = vld_ff[DEPTH-1];
   assign rsp_m_r0c0 = o_ff[0];
   assign rsp_m_r0c1 = o_ff[1];
   assign rsp_m_r0c2 = o_ff[2];
   assign rsp_m_r0c3 = o_ff[3];
   assign rsp_m_r1c0 = o_ff[4];
   assign rsp_m_r1c1 = o_ff[5];
   assign rsp_m_r1c2 = o_ff[6];
   assign rsp_m_r1c3 = o_ff[7];
   assign rsp_m_r2c0 = o_ff[8];
   assign rsp_m_r2c1 = o_ff[9];
   assign rsp_m_r2c2 = o_ff[10];
   assign rsp_m_r2c3 = o_ff[11];
endmodule

>>> rtl/core/trsmb_sincos.sv
// ----------------------------------------------------------------------------
// trsmb_sincos
// pipelined cordic sine and cosine of a binary angle, stall on enable
// ----------------------------------------------------------------------------
module trsmb_sincos #(
   parameter int ANGLE_BITS = trsmb_pkg::ANGLE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [ANGLE_BITS-1:0]   angle,
   output trsmb_pkg::cw_type       sin_out,
   output trsmb_pkg::cw_type       cos_out
);
   import trsmb_pkg::*;

   cordic_type stg_ff [CORDIC_STAGES+1];
   cordic_type stg_in [CORDIC_STAGES+1];

   logic [31:0] t32;
   cw_type      z0;

   always_comb begin
      t32 = {angle, {(32-ANGLE_BITS){1'b0}}};
      z0  = CW'($signed(t32));
      stg_in[0].x   = CORDIC_GAIN;
      stg_in[0].y   = '0;
      stg_in[0].neg = 1'b0;
      stg_in[0].z   = z0;
      if (z0 > 34'sd1073741824) begin
         stg_in[0].z   = z0 - 34'sd2147483648;
         stg_in[0].neg = 1'b1;
      end else if (z0 < -34'sd1073741824) begin
         stg_in[0].z   = z0 + 34'sd2147483648;
         stg_in[0].neg = 1'b1;
      end
      for (int s = 1; s <= CORDIC_STAGES; s++) begin
         stg_in[s] = stg_ff[s-1];
         for (int k = 0; k < STEPS_PER_STG; k++)
            stg_in[s] = cordic_step(stg_in[s], (s-1)*STEPS_PER_STG + k);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s <= CORDIC_STAGES; s++) stg_ff[s] <= stg_in[s];
      end
   end

   assign sin_out = stg_ff[CORDIC_STAGES].neg ? -stg_ff[CORDIC_STAGES].y
                                              : stg_ff[CORDIC_STAGES].y;
   assign cos_out = stg_ff[CORDIC_STAGES].neg ? -stg_ff[CORDIC_STAGES].x
                                              : stg_ff[CORDIC_STAGES].x;
endmodule

>>> rtl/core/trsmb_checker.sv
// ----------------------------------------------------------------------------
// trsmb_checker
// port level checks of the model matrix builder
// ----------------------------------------------------------------------------
module trsmb_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [31:0] rsp_m_r0c0
);
   a_ready_follows_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_ready || !rsp_valid) |-> req_ready) else $error("ready low with free output");
   a_stall_blocks_in: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !(req_valid && req_ready))
      else $error("input taken during stall");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_m_r0c0)))
      else $error("response dropped");
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response after reset");
endmodule

bind trs_model_matrix_builder trsmb_checker u_trsmb_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_m_r0c0(rsp_m_r0c0));
